### design/video_text_overlay_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for video_text_overlay_top
// Shared forms of the clocked, reset-qualified checks.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEXT_OVERLAY_TOP_ASSERT_SVH
`define VIDEO_TEXT_OVERLAY_TOP_ASSERT_SVH

// same-cycle implication
`define VTO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VTO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/vto_pkg.sv
// ----------------------------------------------------------------------------
// vto_pkg
// Types, constants, font and text tables of the video text overlay.
// ----------------------------------------------------------------------------
package vto_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int PIXEL_W        = 24;
    localparam int BOX_WIDTH      = 520;
    localparam int BOX_HEIGHT     = 100;
    localparam int BORDER         = 3;
    localparam int TEXT_LEFT      = 10;
    localparam int CHAR_PITCH     = 6;
    localparam int GLYPH_W        = 5;
    localparam int GLYPH_H        = 7;
    localparam int LINE_COUNT     = 4;
    localparam int ROM_CHARS      = 18;
    localparam int MAX_LINE_CHARS = 18;

    localparam int CC_W   = $clog2(CHAR_PITCH);
    localparam int IDX_W  = 5;
    localparam int LINE_W = $clog2(LINE_COUNT);
    localparam int GROW_W = $clog2(GLYPH_H);
    localparam int CODE_W = 5;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
    localparam logic [PIXEL_W-1:0] WHITE = {PIXEL_W{1'b1}};

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] t_glyph;
    typedef t_code [0:ROM_CHARS-1] t_text_row;

    typedef struct packed {
        logic [PIXEL_W-1:0]     rgb;
        logic                   frame_start;
        logic                   line_end;
        logic [COUNT_WIDTH-1:0] row;
        logic [COUNT_WIDTH-1:0] col;
        logic [CC_W-1:0]        cc;
        logic [IDX_W-1:0]       idx;
    } t_stage;

    // glyph codes
    localparam t_code G_BLANK = 5'd0;
    localparam t_code G_V     = 5'd1;
    localparam t_code G_I     = 5'd2;
    localparam t_code G_C     = 5'd3;
    localparam t_code G_K     = 5'd4;
    localparam t_code G_Y     = 5'd5;
    localparam t_code G_N     = 5'd6;
    localparam t_code G_G     = 5'd7;
    localparam t_code G_W     = 5'd8;
    localparam t_code G_U     = 5'd9;
    localparam t_code G_R     = 5'd10;
    localparam t_code G_A     = 5'd11;
    localparam t_code G_T     = 5'd12;
    localparam t_code G_L     = 5'd13;
    localparam t_code G_S     = 5'd14;
    localparam t_code G_H     = 5'd15;
    localparam t_code G_0     = 5'd16;
    localparam t_code G_1     = 5'd17;
    localparam t_code G_2     = 5'd18;
    localparam t_code G_3     = 5'd19;
    localparam t_code G_4     = 5'd20;
    localparam t_code G_9     = 5'd21;

    function automatic int clip_len(input int n);
        return (n > MAX_LINE_CHARS) ? MAX_LINE_CHARS : n;
    endfunction

    localparam logic [COUNT_WIDTH-1:0] TEXT_TOP [LINE_COUNT] = '{
        COUNT_WIDTH'(15), COUNT_WIDTH'(30), COUNT_WIDTH'(55), COUNT_WIDTH'(70)
    };
    localparam logic [COUNT_WIDTH-1:0] TEXT_BOTTOM [LINE_COUNT] = '{
        COUNT_WIDTH'(15 + GLYPH_H), COUNT_WIDTH'(30 + GLYPH_H),
        COUNT_WIDTH'(55 + GLYPH_H), COUNT_WIDTH'(70 + GLYPH_H)
    };
    localparam logic [IDX_W-1:0] TEXT_LEN [LINE_COUNT] = '{
        IDX_W'(clip_len(18)), IDX_W'(clip_len(8)),
        IDX_W'(clip_len(11)), IDX_W'(clip_len(8))
    };

    localparam t_text_row TEXT_ROM [LINE_COUNT] = '{
        '{G_H, G_U, G_S, G_K, G_Y, G_BLANK, G_T, G_A, G_I, G_L, G_BLANK,
          G_W, G_A, G_G, G_S, G_BLANK, G_1, G_2},
        '{G_A, G_1, G_2, G_0, G_3, G_9, G_4, G_1, G_BLANK, G_BLANK, G_BLANK,
          G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK},
        '{G_N, G_I, G_G, G_H, G_T, G_BLANK, G_C, G_R, G_A, G_W, G_L,
          G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK},
        '{G_S, G_4, G_T, G_9, G_3, G_2, G_1, G_0, G_BLANK, G_BLANK, G_BLANK,
          G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK, G_BLANK}
    };

    // 5x7 font, bit 4 is the leftmost pixel
    function automatic t_glyph glyph_rows(input t_code code);
        t_glyph g;
        case (code)
            G_V:     g = {5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04, 5'h04};
            G_I:     g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            G_C:     g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            G_K:     g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            G_Y:     g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            G_N:     g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            G_G:     g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
            G_W:     g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            G_U:     g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            G_R:     g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            G_A:     g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            G_T:     g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            G_L:     g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            G_S:     g = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
            G_H:     g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            G_0:     g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            G_1:     g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            G_2:     g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            G_3:     g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            G_4:     g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            G_9:     g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### design/vto_pos.sv
// ----------------------------------------------------------------------------
// vto_pos
// Input register and raster position tracking with character cell counters.
// ----------------------------------------------------------------------------
module vto_pos (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_load,
    input  logic [vto_pkg::PIXEL_W-1:0] i_pixel_rgb,
    input  logic                       i_frame_start,
    input  logic                       i_line_end,
    output logic                       o_valid,
    output vto_pkg::t_stage            o_stage
);
    import vto_pkg::*;

    logic [COUNT_WIDTH-1:0] r_row, r_col, n_row, n_col, cur_row, cur_col;
    logic [CC_W-1:0]        r_cc, n_cc, cur_cc;
    logic [IDX_W-1:0]       r_idx, n_idx, cur_idx;
    logic                   r_valid;
    t_stage                 r_stage, n_stage;
    logic                   accept;

    assign accept = i_valid && i_load;

    always_comb begin
        cur_row = i_frame_start ? '0 : r_row;
        cur_col = i_frame_start ? '0 : r_col;
        cur_cc  = i_frame_start ? '0 : r_cc;
        cur_idx = i_frame_start ? '0 : r_idx;

        n_col = i_line_end ? '0 : cur_col + COUNT_WIDTH'(1);
        n_row = i_line_end ? cur_row + COUNT_WIDTH'(1) : cur_row;

        if (i_line_end || (cur_col < COUNT_WIDTH'(TEXT_LEFT))) begin
            n_cc  = '0;
            n_idx = '0;
        end else if (cur_cc == CC_W'(CHAR_PITCH - 1)) begin
            n_cc  = '0;
            n_idx = (cur_idx == IDX_MAX) ? cur_idx : cur_idx + IDX_W'(1);
        end else begin
            n_cc  = cur_cc + CC_W'(1);
            n_idx = cur_idx;
        end

        n_stage.rgb         = i_pixel_rgb;
        n_stage.frame_start = i_frame_start;
        n_stage.line_end    = i_line_end;
        n_stage.row         = cur_row;
        n_stage.col         = cur_col;
        n_stage.cc          = cur_cc;
        n_stage.idx         = cur_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_cc    <= '0;
            r_idx   <= '0;
        end else begin
            if (i_load) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
                r_cc  <= n_cc;
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### design/vto_draw.sv
// ----------------------------------------------------------------------------
// vto_draw
// Box dimming, border and text rendering into the output register, when enabled.
// ----------------------------------------------------------------------------
module vto_draw (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_stage_valid,
    input  vto_pkg::t_stage             i_stage,
    input  logic                        i_enable,
    output logic                        o_valid,
    output logic [vto_pkg::PIXEL_W-1:0] o_rgb,
    output logic                        o_frame_start,
    output logic                        o_line_end
);
    import vto_pkg::*;

    logic                 r_valid;
    logic [PIXEL_W-1:0]   r_rgb, n_rgb, dim_rgb;
    logic                 r_frame_start, r_line_end;
    logic                 in_box, on_border, line_hit, text_on;
    logic [LINE_W-1:0]    line_sel;
    logic [GROW_W-1:0]    grow_sel;
    t_code                code;
    t_glyph               glyph;
    logic [GLYPH_W-1:0]   grow;

    always_comb begin
        line_hit = 1'b0;
        line_sel = '0;
        grow_sel = '0;
        for (int l = 0; l < LINE_COUNT; l++) begin
            if ((i_stage.row >= TEXT_TOP[l]) && (i_stage.row < TEXT_BOTTOM[l])) begin
                line_hit = 1'b1;
                line_sel = LINE_W'(l);
                grow_sel = GROW_W'(i_stage.row - TEXT_TOP[l]);
            end
        end
    end

    always_comb begin
        code    = TEXT_ROM[line_sel][i_stage.idx];
        glyph   = glyph_rows(code);
        grow    = glyph[grow_sel];
        text_on = line_hit
               && (i_stage.col >= COUNT_WIDTH'(TEXT_LEFT))
               && (i_stage.idx < TEXT_LEN[line_sel])
               && (i_stage.cc < CC_W'(GLYPH_W))
               && grow[CC_W'(GLYPH_W - 1) - i_stage.cc];

        in_box    = (i_stage.row < COUNT_WIDTH'(BOX_HEIGHT))
                 && (i_stage.col < COUNT_WIDTH'(BOX_WIDTH));
        on_border = (i_stage.row < COUNT_WIDTH'(BORDER))
                 || (i_stage.row >= COUNT_WIDTH'(BOX_HEIGHT - BORDER))
                 || (i_stage.col < COUNT_WIDTH'(BORDER))
                 || (i_stage.col >= COUNT_WIDTH'(BOX_WIDTH - BORDER));

        dim_rgb = {1'b0, i_stage.rgb[23:17], 1'b0, i_stage.rgb[15:9],
                   1'b0, i_stage.rgb[7:1]};

        n_rgb = i_stage.rgb;
        if (i_enable) begin
            if (in_box) begin
                n_rgb = dim_rgb;
            end
            if ((in_box && on_border) || text_on) begin
                n_rgb = WHITE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_stage_valid) begin
            r_rgb         <= n_rgb;
            r_frame_start <= i_stage.frame_start;
            r_line_end    <= i_stage.line_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_rgb         = r_rgb;
    assign o_frame_start = r_frame_start;
    assign o_line_end    = r_line_end;

endmodule

### design/video_text_overlay_top.sv
// ----------------------------------------------------------------------------
// video_text_overlay_top
// On-screen text overlay for a 24-bit RGB pixel stream.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   pixel   | in        | i_valid / o_stall   | rgb, frame start, line end
//   result  | out       | o_valid / i_stall   | rgb, frame start, line end
//   config  | in        | i_cfg_we            | overlay enable
//
// One pixel per cycle while o_stall is low; each accepted transaction passes
// through the input register, then the overlay logic into the output register,
// and leaves when i_stall is low.
// Synchronous active-low reset clears the valid bits, position counters and
// the enable. o_stall rises only while both registers hold data and i_stall
// is high.
// ----------------------------------------------------------------------------
module video_text_overlay_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [vto_pkg::PIXEL_W-1:0] i_pixel_rgb,
    input  logic                        i_frame_start,
    input  logic                        i_line_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [vto_pkg::PIXEL_W-1:0] o_out_rgb,
    output logic                        o_out_frame_start,
    output logic                        o_out_line_end,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data
);
    import vto_pkg::*;

    logic   r_enable;
    logic   stage_valid, stage_load, out_load;
    t_stage stage;

    assign out_load   = !o_valid || !i_stall;
    assign stage_load = !stage_valid || out_load;
    assign o_stall    = !stage_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_data;
        end
    end

    vto_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_load        (stage_load),
        .i_pixel_rgb   (i_pixel_rgb),
        .i_frame_start (i_frame_start),
        .i_line_end    (i_line_end),
        .o_valid       (stage_valid),
        .o_stage       (stage)
    );

    vto_draw u_draw (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_stage_valid (stage_valid),
        .i_stage       (stage),
        .i_enable      (r_enable),
        .o_valid       (o_valid),
        .o_rgb         (o_out_rgb),
        .o_frame_start (o_out_frame_start),
        .o_line_end    (o_out_line_end)
    );

`include "video_text_overlay_top_assert.svh"

    `VTO_ASSERT_NOW(a_no_stall_when_free, !i_stall, !o_stall, "input stalled with free output")
    `VTO_ASSERT_NEXT(a_corner_white,
        out_load && stage_valid && stage.frame_start && r_enable,
        o_out_rgb == WHITE, "frame corner not white")
    `VTO_ASSERT_NEXT(a_bypass,
        out_load && stage_valid && !r_enable,
        o_out_rgb == $past(stage.rgb), "disabled overlay altered pixel")

endmodule
